/* hdl/mm4_pkg.sv */
// Shared package for the 4x4 fixed-point matrix multiplier.
// Holds default sizes, item mode codes, sequencer states and MAC control.
// No dependencies.
`timescale 1ns / 1ps

package mm4_pkg;

  // Default geometry and number format (signed Q8.8, 4x4)
  localparam int DIM_DEF       = 4;
  localparam int ELEM_W_DEF    = 16;
  localparam int FRAC_BITS_DEF = 8;

  // Input item modes
  localparam logic [1:0] MODE_LOAD_A  = 2'd0;
  localparam logic [1:0] MODE_LOAD_B  = 2'd1;
  localparam logic [1:0] MODE_COMPUTE = 2'd2;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_DRAIN,
    S_EMIT
  } state_t;

  // Control that travels with each operand pair into the MAC unit
  typedef struct packed {
    logic valid;
    logic first;
  } mac_ctrl_t;

endpackage

/* hdl/mm4_mac.sv */
// Shared multiply-accumulate unit: registered product, accumulator,
// floor shift and saturation of the dot product. Depends on mm4_pkg.
`timescale 1ns / 1ps

module mm4_mac #(
  parameter int DIM       = mm4_pkg::DIM_DEF,
  parameter int ELEM_W    = mm4_pkg::ELEM_W_DEF,
  parameter int FRAC_BITS = mm4_pkg::FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  mm4_pkg::mac_ctrl_t       ctrl,
  input  logic signed [ELEM_W-1:0] op_a,
  input  logic signed [ELEM_W-1:0] op_b,
  output logic signed [ELEM_W-1:0] res,
  output logic                     res_sat
);

  localparam int PROD_W = 2 * ELEM_W;
  localparam int ACC_W  = PROD_W + $clog2(DIM);

  localparam logic [ELEM_W-1:0] ELEM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam logic [ELEM_W-1:0] ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

  mm4_pkg::mac_ctrl_t        pctl_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [ACC_W-1:0]   acc_nxt;
  logic signed [ACC_W-1:0]   shifted;
  logic [ACC_W-ELEM_W:0]     top_bits;
  logic                      fits;

  // Multiplier stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pctl_r <= '0;
    end else begin
      pctl_r <= ctrl;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  // Accumulator: the first product of a dot product restarts the sum
  always_comb begin
    if (pctl_r.first) begin
      acc_nxt = ACC_W'(prod_r);
    end else begin
      acc_nxt = acc_r + ACC_W'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    if (pctl_r.valid) begin
      acc_r <= acc_nxt;
    end
  end

  // Floor shift, then clip to the element range
  always_comb begin
    shifted  = acc_r >>> FRAC_BITS;
    top_bits = shifted[ACC_W-1:ELEM_W-1];
    fits     = (&top_bits) || !(|top_bits);
    res_sat  = !fits;
    if (fits) begin
      res = shifted[ELEM_W-1:0];
    end else if (shifted[ACC_W-1]) begin
      res = ELEM_MIN;
    end else begin
      res = ELEM_MAX;
    end
  end

endmodule

/* hdl/matrix_multiply_4x4.sv */
// Top level of the fixed-point matrix multiplier: element stores, sequencer
// and output register. Depends on mm4_pkg and mm4_mac.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_*): a load item (mode A or B) writes one element at
//   in_row/in_col. A compute item starts the product
//   A x B; the block stalls its input until the sixteenth result is in
//   the output register. Mode 3 and out-of-range indexes are dropped.
//   Output channel (out_*): one transfer per product element, row-major,
//   out_last marks the final element, out_saturated marks a clipped value.
//   Timing: one shared multiply-accumulate unit and one read port per
//   store. Each element issues DIM store reads into the MAC (S_ISSUE),
//   waits in S_DRAIN while the product and accumulator registers fill,
//   then is written to the output register in S_EMIT.
//   Stall: a finished element waits in the output register; the sequencer
//   holds until it is taken. Loads may be accepted while the last element
//   still waits.
//   Reset: the sequencer and output valid clear. Store contents are
//   undefined until written; every element must be loaded before use.

module matrix_multiply_4x4 #(
  parameter int DIM       = mm4_pkg::DIM_DEF,
  parameter int ELEM_W    = mm4_pkg::ELEM_W_DEF,
  parameter int FRAC_BITS = mm4_pkg::FRAC_BITS_DEF,
  localparam int IDX_W    = $clog2(DIM)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // input channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_mode,
  input  logic [IDX_W-1:0]         in_row,
  input  logic [IDX_W-1:0]         in_col,
  input  logic signed [ELEM_W-1:0] in_value,
  // result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [IDX_W-1:0]         out_row,
  output logic [IDX_W-1:0]         out_col,
  output logic signed [ELEM_W-1:0] out_product,
  output logic                     out_saturated,
  output logic                     out_last
);

  localparam int CELLS = DIM * DIM;
  localparam int AW    = $clog2(CELLS);
  localparam logic [AW-1:0]    DIM_A    = AW'(DIM);
  localparam logic [IDX_W:0]   DIM_X    = (IDX_W+1)'(DIM);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DIM - 1);

  mm4_pkg::state_t state_r, state_nxt;

  logic [IDX_W-1:0]         r_r, c_r, i_r;
  logic                     drain_r;
  logic                     in_xfer;
  logic                     in_range;
  logic                     wr_a, wr_b;
  logic                     start;
  logic                     issue_en;
  logic                     emit_en;
  logic                     elem_last;
  logic [AW-1:0]            wr_addr, rd_addr_a, rd_addr_b;

  logic [ELEM_W-1:0]        a_mem [CELLS];
  logic [ELEM_W-1:0]        b_mem [CELLS];
  logic signed [ELEM_W-1:0] a_q_r, b_q_r;
  mm4_pkg::mac_ctrl_t       rd_ctrl_r;

  logic signed [ELEM_W-1:0] mac_res;
  logic                     mac_sat;

  logic                     out_valid_r;
  logic [IDX_W-1:0]         out_row_r, out_col_r;
  logic signed [ELEM_W-1:0] out_product_r;
  logic                     out_sat_r, out_last_r;

  // Input decode
  assign in_xfer   = in_valid && !in_stall;
  assign in_range  = ({1'b0, in_row} < DIM_X) && ({1'b0, in_col} < DIM_X);
  assign wr_a      = in_xfer && in_range && (in_mode == mm4_pkg::MODE_LOAD_A);
  assign wr_b      = in_xfer && in_range && (in_mode == mm4_pkg::MODE_LOAD_B);
  assign start     = in_xfer && (in_mode == mm4_pkg::MODE_COMPUTE);
  assign elem_last = (r_r == IDX_LAST) && (c_r == IDX_LAST);

  // Row-major addresses
  assign wr_addr   = AW'(in_row) * DIM_A + AW'(in_col);
  assign rd_addr_a = AW'(r_r) * DIM_A + AW'(i_r);
  assign rd_addr_b = AW'(i_r) * DIM_A + AW'(c_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mm4_pkg::S_IDLE: begin
        if (start) state_nxt = mm4_pkg::S_ISSUE;
      end
      mm4_pkg::S_ISSUE: begin
        if (i_r == IDX_LAST) state_nxt = mm4_pkg::S_DRAIN;
      end
      mm4_pkg::S_DRAIN: begin
        if (drain_r) state_nxt = mm4_pkg::S_EMIT;
      end
      mm4_pkg::S_EMIT: begin
        if (emit_en) state_nxt = elem_last ? mm4_pkg::S_IDLE : mm4_pkg::S_ISSUE;
      end
      default: state_nxt = mm4_pkg::S_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_stall = 1'b1;
    issue_en = 1'b0;
    emit_en  = 1'b0;
    case (state_r)
      mm4_pkg::S_IDLE:  in_stall = 1'b0;
      mm4_pkg::S_ISSUE: issue_en = 1'b1;
      mm4_pkg::S_DRAIN: ;
      mm4_pkg::S_EMIT:  emit_en  = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  // Sequencer registers and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mm4_pkg::S_IDLE;
      r_r     <= '0;
      c_r     <= '0;
      i_r     <= '0;
      drain_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (start) begin
        r_r <= '0;
        c_r <= '0;
        i_r <= '0;
      end
      if (issue_en) begin
        i_r <= (i_r == IDX_LAST) ? '0 : i_r + 1'b1;
      end
      drain_r <= (state_r == mm4_pkg::S_DRAIN) && !drain_r;
      if (emit_en) begin
        if (c_r == IDX_LAST) begin
          c_r <= '0;
          r_r <= (r_r == IDX_LAST) ? '0 : r_r + 1'b1;
        end else begin
          c_r <= c_r + 1'b1;
        end
      end
    end
  end

  // Element stores with registered reads
  always_ff @(posedge clk) begin
    if (wr_a) a_mem[wr_addr] <= in_value;
    if (wr_b) b_mem[wr_addr] <= in_value;
    if (issue_en) begin
      a_q_r <= a_mem[rd_addr_a];
      b_q_r <= b_mem[rd_addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ctrl_r <= '0;
    end else begin
      rd_ctrl_r.valid <= issue_en;
      rd_ctrl_r.first <= issue_en && (i_r == '0);
    end
  end

  mm4_mac #(
    .DIM       (DIM),
    .ELEM_W    (ELEM_W),
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (rd_ctrl_r),
    .op_a    (a_q_r),
    .op_b    (b_q_r),
    .res     (mac_res),
    .res_sat (mac_sat)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_en) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_en) begin
      out_row_r     <= r_r;
      out_col_r     <= c_r;
      out_product_r <= mac_res;
      out_sat_r     <= mac_sat;
      out_last_r    <= elem_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_row       = out_row_r;
  assign out_col       = out_col_r;
  assign out_product   = out_product_r;
  assign out_saturated = out_sat_r;
  assign out_last      = out_last_r;

`ifndef SYNTHESIS
  // A compute transfer always starts the read sequence
  a_start_issue: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> state_r == mm4_pkg::S_ISSUE)
    else $error("compute transfer did not start issuing");

  // Operands reach the MAC only in the cycle after an issue cycle
  a_rd_from_issue: assert property (@(posedge clk) disable iff (!rst_n)
    rd_ctrl_r.valid |-> $past(state_r) == mm4_pkg::S_ISSUE)
    else $error("MAC operand without a read issue");

  // An element is emitted only after the pipeline drained
  a_emit_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mm4_pkg::S_EMIT) |->
      ($past(state_r) == mm4_pkg::S_DRAIN || $past(state_r) == mm4_pkg::S_EMIT))
    else $error("emit entered without pipeline drain");

  // No new element is loaded over one that still waits
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    emit_en |-> (!out_valid_r || !out_stall))
    else $error("output register overwritten while stalled");
`endif

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for the 4x4 signed Q8.8 matrix multiplier.
// Depends on mm4_pkg and matrix_multiply_4x4; keeps its own copy of both stores.
`timescale 1ns / 1ps

module tb;

  localparam int DIM       = mm4_pkg::DIM_DEF;
  localparam int ELEM_W    = mm4_pkg::ELEM_W_DEF;
  localparam int FRAC_BITS = mm4_pkg::FRAC_BITS_DEF;
  localparam int IDX_W     = $clog2(DIM);

  // Mode 3 is not decoded by the block
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam longint ELEM_MAX = (longint'(1) <<< (ELEM_W - 1)) - 1;
  localparam longint ELEM_MIN = -ELEM_MAX - 1;

  // Quiet cycles allowed with no transfer on either channel
  localparam int QUIET_LIMIT  = 2000;
  // Cycles to watch for stray results once all products are in
  localparam int TAIL_CYCLES  = 4 * (DIM + 3);

  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic signed [ELEM_W-1:0] q_elem_t;

  localparam q_elem_t Q_MAX     = 16'sh7FFF;
  localparam q_elem_t Q_MIN     = 16'sh8000;
  localparam q_elem_t Q_ONE     = 16'sh0100;
  localparam q_elem_t Q_LSB     = 16'sh0001;
  localparam q_elem_t Q_NEG_LSB = 16'shFFFF;

  typedef struct {
    idx_t    row;
    idx_t    col;
    q_elem_t product;
    logic    sat;
    logic    last;
  } prod_elem_t;

  logic    clk;
  logic    rst_n     = 1'b0;
  logic    in_valid  = 1'b0;
  logic    in_stall;
  logic [1:0] in_mode = mm4_pkg::MODE_LOAD_A;
  idx_t    in_row    = '0;
  idx_t    in_col    = '0;
  q_elem_t in_value  = '0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  idx_t    out_row;
  idx_t    out_col;
  q_elem_t out_product;
  logic    out_saturated;
  logic    out_last;

  // Shadow copies of both operand stores
  q_elem_t mat_a [DIM][DIM];
  q_elem_t mat_b [DIM][DIM];

  // Product elements predicted but not yet seen on the result channel
  prod_elem_t pending_elems[$];

  int in_idle_pct   = 0;
  int out_stall_pct = 0;
  int mismatches    = 0;
  int n_loads       = 0;
  int n_computes    = 0;
  int n_ignored     = 0;
  int n_elems       = 0;
  int n_clipped     = 0;
  int quiet_cycles  = 0;

  matrix_multiply_4x4 dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_mode       (in_mode),
    .in_row        (in_row),
    .in_col        (in_col),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_row       (out_row),
    .out_col       (out_col),
    .out_product   (out_product),
    .out_saturated (out_saturated),
    .out_last      (out_last)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // Full A x B product: exact dot products, floor shift, clip to element range
  function automatic void multiply_stores();
    longint     acc;
    prod_elem_t e;
    for (int r = 0; r < DIM; r++) begin
      for (int c = 0; c < DIM; c++) begin
        acc = 0;
        for (int i = 0; i < DIM; i++) begin
          acc += longint'(mat_a[r][i]) * longint'(mat_b[i][c]);
        end
        acc = acc >>> FRAC_BITS;
        e.row  = idx_t'(r);
        e.col  = idx_t'(c);
        e.last = (r == DIM - 1) && (c == DIM - 1);
        if (acc > ELEM_MAX) begin
          e.product = q_elem_t'(ELEM_MAX);
          e.sat     = 1'b1;
        end else if (acc < ELEM_MIN) begin
          e.product = q_elem_t'(ELEM_MIN);
          e.sat     = 1'b1;
        end else begin
          e.product = q_elem_t'(acc);
          e.sat     = 1'b0;
        end
        pending_elems.push_back(e);
      end
    end
  endfunction

  // Mostly small values so sums stay in range, plus full-range and corner values
  function automatic q_elem_t rand_elem();
    int pick;
    pick = $urandom_range(9);
    if (pick < 5) return q_elem_t'(int'($urandom_range(2047)) - 1024);
    if (pick < 8) return q_elem_t'($urandom);
    case ($urandom_range(4))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return Q_ONE;
      3: return Q_NEG_LSB;
      default: return '0;
    endcase
  endfunction

  // One input transfer; the shadow stores follow at the accepting edge
  task automatic send_item(input logic [1:0] mode, input idx_t row, input idx_t col,
                           input q_elem_t value);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode  <= mode;
    in_row   <= row;
    in_col   <= col;
    in_value <= value;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    case (mode)
      mm4_pkg::MODE_LOAD_A: begin
        mat_a[row][col] = value;
        n_loads++;
      end
      mm4_pkg::MODE_LOAD_B: begin
        mat_b[row][col] = value;
        n_loads++;
      end
      mm4_pkg::MODE_COMPUTE: begin
        multiply_stores();
        n_computes++;
      end
      default: n_ignored++;
    endcase
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_elems.size() != 0) @(posedge clk);
  endtask

  task automatic set_idling(input int in_pct, input int out_pct);
    in_idle_pct   = in_pct;
    out_stall_pct = out_pct;
  endtask

  // Fills both stores with corner values; one product covers clipping
  // both ways, exact range limits and floor rounding of negative sums
  task automatic test_saturation_and_rounding();
    q_elem_t v;
    for (int r = 0; r < DIM; r++) begin
      for (int c = 0; c < DIM; c++) begin
        case (r)
          0: v = Q_MAX;
          1: v = Q_MIN;
          2: v = (c == 0) ? Q_ONE : q_elem_t'(0);
          default: v = (c == 0) ? Q_NEG_LSB : q_elem_t'(0);
        endcase
        send_item(mm4_pkg::MODE_LOAD_A, idx_t'(r), idx_t'(c), v);
      end
    end
    for (int r = 0; r < DIM; r++) begin
      for (int c = 0; c < DIM; c++) begin
        case (c)
          0: v = Q_MAX;
          1: v = Q_MIN;
          2: v = Q_ONE;
          default: v = Q_LSB;
        endcase
        send_item(mm4_pkg::MODE_LOAD_B, idx_t'(r), idx_t'(c), v);
      end
    end
    send_item(mm4_pkg::MODE_COMPUTE, '0, '0, '0);
  endtask

  // Unused mode must not touch either store; one LSB pushes a limit value over
  task automatic test_unused_mode_and_edges();
    send_item(MODE_UNUSED, '0, '0, 16'sh1234);
    send_item(MODE_UNUSED, idx_t'(DIM - 1), idx_t'(DIM - 1), Q_MIN);
    send_item(mm4_pkg::MODE_LOAD_A, idx_t'(2), idx_t'(1), Q_LSB);
    send_item(mm4_pkg::MODE_COMPUTE, idx_t'(DIM - 1), idx_t'(DIM - 1), Q_NEG_LSB);
  endtask

  // Bursts of loads closed by a compute, with occasional unused-mode noise
  task automatic test_random_traffic(input int n_items);
    int   sent;
    int   burst;
    logic to_b;
    sent = 0;
    while (sent < n_items) begin
      burst = $urandom_range(12, 1);
      repeat (burst) begin
        if ($urandom_range(19) == 0) begin
          send_item(MODE_UNUSED, idx_t'($urandom), idx_t'($urandom), q_elem_t'($urandom));
        end
        to_b = $urandom_range(1);
        send_item(to_b ? mm4_pkg::MODE_LOAD_B : mm4_pkg::MODE_LOAD_A, idx_t'($urandom),
                  idx_t'($urandom), rand_elem());
        sent++;
      end
      // row, col and value are don't-care for a compute
      send_item(mm4_pkg::MODE_COMPUTE, idx_t'($urandom), idx_t'($urandom),
                q_elem_t'($urandom));
      sent++;
    end
  endtask

  // Sender holds off until the product is fully out, then back-to-back computes
  task automatic test_pause_for_drain();
    send_item(mm4_pkg::MODE_LOAD_A, idx_t'($urandom), idx_t'($urandom), rand_elem());
    send_item(mm4_pkg::MODE_COMPUTE, '0, '0, '0);
    wait_drained();
    send_item(mm4_pkg::MODE_LOAD_B, idx_t'($urandom), idx_t'($urandom), rand_elem());
    send_item(mm4_pkg::MODE_COMPUTE, '0, '0, '0);
    send_item(mm4_pkg::MODE_COMPUTE, '0, '0, '0);
    wait_drained();
  endtask

  // Result check and receiver stall
  always @(posedge clk) begin
    prod_elem_t e;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_elems.size() == 0) begin
        report_mismatch("result with nothing pending, product", out_product, 0);
      end else begin
        e = pending_elems.pop_front();
        if (out_row !== e.row) report_mismatch("out_row", out_row, e.row);
        if (out_col !== e.col) report_mismatch("out_col", out_col, e.col);
        if (out_product !== e.product) report_mismatch("out_product", out_product, e.product);
        if (out_saturated !== e.sat) report_mismatch("out_saturated", out_saturated, e.sat);
        if (out_last !== e.last) report_mismatch("out_last", out_last, e.last);
        n_elems++;
        if (e.sat) n_clipped++;
      end
    end
    out_stall <= rst_n && ($urandom_range(99) < out_stall_pct);
  end

  // Watchdog on transfer activity
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Every element gets written here before the first compute reads it
    set_idling(0, 0);
    test_saturation_and_rounding();
    test_unused_mode_and_edges();
    test_random_traffic(30);

    set_idling(60, 0);
    test_random_traffic(30);

    set_idling(0, 60);
    test_random_traffic(30);

    set_idling(11, 11);
    test_pause_for_drain();
    test_random_traffic(30);

    // Wind down: all products out, then watch for strays
    in_valid <= 1'b0;
    while (pending_elems.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d load, %0d compute and %0d unused-mode transfers; %0d elements checked,",
             n_loads, n_computes, n_ignored, n_elems);
    $display("%0d of them clipped, over idle-free, sender-gap, receiver-stall and mixed phases.",
             n_clipped);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
